// ===== rtl/hut_pkg.sv =====
// ----------------------------------------------------------------------------
// hut_pkg
// Types and constants shared by the hex text to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package hut_pkg;

    localparam int unsigned GrpBytes = 5;

    typedef enum logic [1:0] {
        REASON_TERM   = 2'd0,
        REASON_BUDGET = 2'd1,
        REASON_NOFIT  = 2'd2
    } t_reason;

    localparam logic [7:0]  CHR_NUL   = 8'h00;
    localparam logic [7:0]  CHR_QUOTE = 8'h22;
    localparam logic [7:0]  CHR_SPACE = 8'h20;
    localparam logic [7:0]  CHR_LOW_A = 8'h61;
    localparam logic [7:0]  CHR_UP_A  = 8'h41;
    localparam logic [7:0]  CHR_ZERO  = 8'h30;

    localparam logic [15:0] LIM_1B    = 16'h007F;
    localparam logic [15:0] LIM_2B    = 16'h07FF;
    localparam logic [15:0] LIM_3B    = 16'hD7FF;
    localparam logic [15:0] LIM_LEAD  = 16'hF8FF;
    localparam logic [15:0] LEAD_OFS  = 16'h0040;

    localparam logic [7:0]  PFX_2B    = 8'hC0;
    localparam logic [7:0]  PFX_3B    = 8'hE0;
    localparam logic [7:0]  PFX_4B    = 8'hF0;
    localparam logic [7:0]  PFX_CONT  = 8'h80;

    // result bytes caused by one input word
    typedef struct packed {
        logic [GrpBytes-1:0][7:0] bytes;
        logic [2:0]               cnt;
        logic                     fin;
        t_reason                  why;
    } t_grp;

endpackage

// ===== rtl/hut_in_if.sv =====
// ----------------------------------------------------------------------------
// hut_in_if
// Input channel: one hex text character per word.
// ----------------------------------------------------------------------------
interface hut_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  char_in;
    logic        first_char;
    logic [15:0] out_budget;

    modport source (output valid, output char_in, output first_char, output out_budget,
                    input ready);
    modport sink   (input valid, input char_in, input first_char, input out_budget,
                    output ready);
endinterface

// ===== rtl/hut_out_if.sv =====
// ----------------------------------------------------------------------------
// hut_out_if
// Output channel: one UTF-8 byte or the terminating zero per word.
// ----------------------------------------------------------------------------
interface hut_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;
    logic [1:0] end_reason;

    modport source (output valid, output out_byte, output last_byte, output end_reason,
                    input ready);
    modport sink   (input valid, input out_byte, input last_byte, input end_reason,
                    output ready);
endinterface

// ===== rtl/hex_ucs2_to_utf8_transcoder_top.sv =====
// ----------------------------------------------------------------------------
// hex_ucs2_to_utf8_transcoder_top
// Result groups are registered, into the draining slot or else the pending slot.
// Throughput: one input word per cycle while the pending group slot is free;
// output runs one byte per cycle while the sink is ready.
// Two result groups are buffered (draining + pending); input stalls when full.
// Reset (synchronous, active low) clears the string state and empties the queue.
// ----------------------------------------------------------------------------
module hex_ucs2_to_utf8_transcoder_top (
    input  logic  i_clk,
    input  logic  i_rst_n,
    hut_in_if.sink    i_in,
    hut_out_if.source o_out
);

    // string state
    logic [15:0] r_accum,   n_accum;
    logic [1:0]  r_nib_cnt, n_nib_cnt;
    logic        r_lead_pend, n_lead_pend;
    logic [15:0] r_lead,    n_lead;
    logic [15:0] r_left,    n_left;
    logic        r_at_start, n_at_start;
    logic        r_done,    n_done;

    // result queue
    hut_pkg::t_grp r_cur, r_pend, g_new;
    logic          r_cur_vld, r_pend_vld;
    logic [2:0]    r_idx;

    logic          in_fire, out_fire, idx_last, cur_free, new_vld;
    logic          go;
    logic [7:0]    c;
    logic [7:0]    nib_full;
    logic [15:0]   v, v1;

    assign c        = i_in.char_in;
    assign i_in.ready = !r_pend_vld;
    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = o_out.valid && o_out.ready;
    assign idx_last = (r_idx == r_cur.cnt - 3'd1);
    assign cur_free = !r_cur_vld || (out_fire && idx_last);
    assign new_vld  = in_fire && (g_new.cnt != 3'd0);

    // hex digit by subtraction, low four bits kept
    always_comb begin
        priority if (c >= hut_pkg::CHR_LOW_A) begin
            nib_full = c - hut_pkg::CHR_LOW_A + 8'd10;
        end else if (c >= hut_pkg::CHR_UP_A) begin
            nib_full = c - hut_pkg::CHR_UP_A + 8'd10;
        end else begin
            nib_full = c - hut_pkg::CHR_ZERO;
        end
    end

    always_comb begin
        n_accum    = r_accum;
        n_nib_cnt  = r_nib_cnt;
        n_lead_pend = r_lead_pend;
        n_lead     = r_lead;
        n_left     = r_left;
        n_at_start = r_at_start;
        n_done     = r_done;
        g_new      = '0;
        go         = 1'b1;
        v          = '0;
        v1         = '0;

        if (i_in.first_char) begin
            n_accum     = '0;
            n_nib_cnt   = '0;
            n_lead_pend = 1'b0;
            n_lead      = '0;
            n_left      = i_in.out_budget;
            n_at_start  = 1'b1;
            n_done      = 1'b0;
            if (i_in.out_budget <= 16'd1) begin
                n_at_start = 1'b0;
                n_done     = 1'b1;
                g_new.fin  = 1'b1;
                g_new.why  = hut_pkg::REASON_BUDGET;
                g_new.cnt  = 3'd1;
                go         = 1'b0;
            end
        end

        if (go && n_done) begin
            go = 1'b0;
        end

        // optional leading quote
        if (go && n_at_start) begin
            n_at_start = 1'b0;
            if (c == hut_pkg::CHR_QUOTE) begin
                go = 1'b0;
            end
        end

        // terminator only on a unit boundary outside a pair
        if (go && n_nib_cnt == 2'd0 && !n_lead_pend &&
            (c == hut_pkg::CHR_NUL || c == hut_pkg::CHR_QUOTE)) begin
            n_done    = 1'b1;
            g_new.fin = 1'b1;
            g_new.why = hut_pkg::REASON_TERM;
            g_new.cnt = 3'd1;
            go        = 1'b0;
        end

        if (go) begin
            n_accum = {n_accum[11:0], nib_full[3:0]};
            if (n_nib_cnt != 2'd3) begin
                n_nib_cnt = n_nib_cnt + 2'd1;
                go        = 1'b0;
            end else begin
                n_nib_cnt = 2'd0;
            end
        end

        if (go) begin
            v  = n_accum;
            v1 = n_lead + hut_pkg::LEAD_OFS;
            priority if (n_lead_pend) begin
                g_new.bytes[0] = hut_pkg::PFX_4B | {5'd0, v1[10:8]};
                g_new.bytes[1] = hut_pkg::PFX_CONT | {2'd0, v1[7:2]};
                g_new.bytes[2] = hut_pkg::PFX_CONT | {2'd0, v1[1:0], v[9:6]};
                g_new.bytes[3] = hut_pkg::PFX_CONT | {2'd0, v[5:0]};
                g_new.cnt      = 3'd4;
                n_left         = n_left - 16'd4;
                n_lead_pend    = 1'b0;
            end else if (v <= hut_pkg::LIM_1B) begin
                g_new.bytes[0] = v[7:0];
                g_new.cnt      = 3'd1;
                n_left         = n_left - 16'd1;
            end else if (v <= hut_pkg::LIM_2B) begin
                if (n_left < 16'd3) begin
                    go = 1'b0;
                end else begin
                    g_new.bytes[0] = hut_pkg::PFX_2B | {3'd0, v[10:6]};
                    g_new.bytes[1] = hut_pkg::PFX_CONT | {2'd0, v[5:0]};
                    g_new.cnt      = 3'd2;
                    n_left         = n_left - 16'd2;
                end
            end else if (v <= hut_pkg::LIM_3B) begin
                if (n_left < 16'd4) begin
                    go = 1'b0;
                end else begin
                    g_new.bytes[0] = hut_pkg::PFX_3B | {4'd0, v[15:12]};
                    g_new.bytes[1] = hut_pkg::PFX_CONT | {2'd0, v[11:6]};
                    g_new.bytes[2] = hut_pkg::PFX_CONT | {2'd0, v[5:0]};
                    g_new.cnt      = 3'd3;
                    n_left         = n_left - 16'd3;
                end
            end else if (v <= hut_pkg::LIM_LEAD) begin
                if (n_left < 16'd5) begin
                    go = 1'b0;
                end else begin
                    n_lead_pend = 1'b1;
                    n_lead      = v;
                end
            end else begin
                g_new.bytes[0] = hut_pkg::CHR_SPACE;
                g_new.cnt      = 3'd1;
                n_left         = n_left - 16'd1;
            end

            if (!go) begin
                // sequence does not fit
                n_done    = 1'b1;
                g_new.fin = 1'b1;
                g_new.why = hut_pkg::REASON_NOFIT;
                g_new.cnt = 3'd1;
            end else if (!n_lead_pend && n_left <= 16'd1) begin
                // final zero after the unit bytes; byte slot already zero
                n_done    = 1'b1;
                g_new.fin = 1'b1;
                g_new.why = hut_pkg::REASON_BUDGET;
                g_new.cnt = g_new.cnt + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum     <= '0;
            r_nib_cnt   <= '0;
            r_lead_pend <= 1'b0;
            r_lead      <= '0;
            r_left      <= '0;
            r_at_start  <= 1'b1;
            r_done      <= 1'b1;
        end else if (in_fire) begin
            r_accum     <= n_accum;
            r_nib_cnt   <= n_nib_cnt;
            r_lead_pend <= n_lead_pend;
            r_lead      <= n_lead;
            r_left      <= n_left;
            r_at_start  <= n_at_start;
            r_done      <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
            r_idx      <= '0;
        end else begin
            if (cur_free) begin
                r_idx <= '0;
                if (r_pend_vld) begin
                    r_cur      <= r_pend;
                    r_cur_vld  <= 1'b1;
                    r_pend     <= g_new;
                    r_pend_vld <= new_vld;
                end else begin
                    r_cur      <= g_new;
                    r_cur_vld  <= new_vld;
                end
            end else begin
                if (out_fire) begin
                    r_idx <= r_idx + 3'd1;
                end
                if (new_vld) begin
                    r_pend     <= g_new;
                    r_pend_vld <= 1'b1;
                end
            end
        end
    end

    assign o_out.valid      = r_cur_vld;
    assign o_out.out_byte   = r_cur.bytes[r_idx];
    assign o_out.last_byte  = r_cur.fin && idx_last;
    assign o_out.end_reason = (r_cur.fin && idx_last) ? r_cur.why : hut_pkg::REASON_TERM;

endmodule

// ===== verif/hex_ucs2_to_utf8_transcoder_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hex_ucs2_to_utf8_transcoder_top_test
// Drives hex text strings into the transcoder and predicts every UTF-8 byte
// and terminating zero in the testbench. Covers the budget, terminator and
// no-fit endings, lead-unit pairs and noise, with random gaps on both sides.
// ----------------------------------------------------------------------------
module hex_ucs2_to_utf8_transcoder_top_test;

    localparam int unsigned RandItems   = 185;
    localparam int unsigned CycleLimit  = 400000;
    localparam int unsigned DrainCycles = 16;

    localparam logic [15:0] UNIT_BOUNDS [10] = '{
        16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800,
        16'hD7FF, 16'hD800, 16'hF8FF, 16'hF900, 16'hFFFF
    };

    typedef struct packed {
        logic [7:0]       data;
        logic             is_last;
        hut_pkg::t_reason why;
    } t_utf8_word;

    logic i_clk;
    logic i_rst_n;

    hut_in_if  in_ch ();
    hut_out_if out_ch ();

    hex_ucs2_to_utf8_transcoder_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_utf8_word  utf8_q [$];
    int unsigned n_errors;
    int unsigned n_items;
    int unsigned cycles;
    int unsigned src_calm;

    // transcoder state as the testbench sees it
    logic [15:0] unit_acc;
    logic [1:0]  nib_cnt;
    logic        lead_pend;
    logic [15:0] lead_val;
    logic [15:0] room;
    logic        at_start;
    logic        str_done;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void push_byte(input logic [7:0] b);
        utf8_q.push_back('{data: b, is_last: 1'b0, why: hut_pkg::REASON_TERM});
    endfunction

    function automatic void end_string(input hut_pkg::t_reason r);
        str_done = 1'b1;
        utf8_q.push_back('{data: 8'h00, is_last: 1'b1, why: r});
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        if (c >= hut_pkg::CHR_LOW_A) begin
            v = c - hut_pkg::CHR_LOW_A + 8'd10;
        end else if (c >= hut_pkg::CHR_UP_A) begin
            v = c - hut_pkg::CHR_UP_A + 8'd10;
        end else begin
            v = c - hut_pkg::CHR_ZERO;
        end
        return v[3:0];
    endfunction

    function automatic void predict_utf8(input logic [7:0] c, input logic first,
                                         input logic [15:0] budget);
        logic [15:0] v;
        logic [15:0] v1;
        if (first) begin
            unit_acc  = '0;
            nib_cnt   = '0;
            lead_pend = 1'b0;
            lead_val  = '0;
            room      = budget;
            at_start  = 1'b1;
            str_done  = 1'b0;
            if (room <= 16'd1) begin
                at_start = 1'b0;
                end_string(hut_pkg::REASON_BUDGET);
                return;
            end
        end
        if (str_done) return;
        if (at_start) begin
            at_start = 1'b0;
            if (c == hut_pkg::CHR_QUOTE) return;
        end
        // terminators only count at a unit boundary and never right after a lead unit
        if (nib_cnt == 2'd0 && !lead_pend &&
            (c == hut_pkg::CHR_NUL || c == hut_pkg::CHR_QUOTE)) begin
            end_string(hut_pkg::REASON_TERM);
            return;
        end
        unit_acc = {unit_acc[11:0], hex_value(c)};
        if (nib_cnt != 2'd3) begin
            nib_cnt++;
            return;
        end
        nib_cnt = 2'd0;
        v = unit_acc;
        if (lead_pend) begin
            v1 = lead_val + hut_pkg::LEAD_OFS;
            push_byte(hut_pkg::PFX_4B   | {5'b0, v1[10:8]});
            push_byte(hut_pkg::PFX_CONT | {2'b0, v1[7:2]});
            push_byte(hut_pkg::PFX_CONT | {2'b0, v1[1:0], v[9:6]});
            push_byte(hut_pkg::PFX_CONT | {2'b0, v[5:0]});
            room      = room - 16'd4;
            lead_pend = 1'b0;
        end else if (v <= hut_pkg::LIM_1B) begin
            push_byte(v[7:0]);
            room = room - 16'd1;
        end else if (v <= hut_pkg::LIM_2B) begin
            if (room < 16'd3) begin
                end_string(hut_pkg::REASON_NOFIT);
                return;
            end
            push_byte(hut_pkg::PFX_2B   | {3'b0, v[10:6]});
            push_byte(hut_pkg::PFX_CONT | {2'b0, v[5:0]});
            room = room - 16'd2;
        end else if (v <= hut_pkg::LIM_3B) begin
            if (room < 16'd4) begin
                end_string(hut_pkg::REASON_NOFIT);
                return;
            end
            push_byte(hut_pkg::PFX_3B   | {4'b0, v[15:12]});
            push_byte(hut_pkg::PFX_CONT | {2'b0, v[11:6]});
            push_byte(hut_pkg::PFX_CONT | {2'b0, v[5:0]});
            room = room - 16'd3;
        end else if (v <= hut_pkg::LIM_LEAD) begin
            // lead unit needs its four bytes plus the zero
            if (room < 16'd5) begin
                end_string(hut_pkg::REASON_NOFIT);
                return;
            end
            lead_pend = 1'b1;
            lead_val  = v;
            return;
        end else begin
            push_byte(hut_pkg::CHR_SPACE);
            room = room - 16'd1;
        end
        if (room <= 16'd1) end_string(hut_pkg::REASON_BUDGET);
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (src_calm != 0) begin
            src_calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) src_calm = $urandom_range(20, 60);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        if (d < 4'd10) return hut_pkg::CHR_ZERO + {4'h0, d};
        if ($urandom_range(0, 1) != 0) return hut_pkg::CHR_LOW_A + {4'h0, d} - 8'd10;
        return hut_pkg::CHR_UP_A + {4'h0, d} - 8'd10;
    endfunction

    function automatic void add_unit(ref logic [7:0] txt [$], input logic [15:0] u,
                                     input int unsigned noise_pct);
        for (int i = 3; i >= 0; i--) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                txt.push_back(8'($urandom_range(0, 255)));
            end else begin
                txt.push_back(hex_char(u[4*i +: 4]));
            end
        end
    endfunction

    function automatic logic [15:0] pick_unit();
        case ($urandom_range(0, 5))
            0: return UNIT_BOUNDS[$urandom_range(0, 9)];
            1: return 16'($urandom_range(16'h0000, 16'h007F));
            2: return 16'($urandom_range(16'h0080, 16'h07FF));
            3: return 16'($urandom_range(16'h0800, 16'hD7FF));
            4: return 16'($urandom_range(16'hD800, 16'hF8FF));
            default: return 16'($urandom_range(16'hF900, 16'hFFFF));
        endcase
    endfunction

    task automatic send_word(input logic [7:0] c, input logic first,
                             input logic [15:0] budget);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid      <= 1'b1;
        in_ch.char_in    <= c;
        in_ch.first_char <= first;
        in_ch.out_budget <= budget;
        do @(posedge i_clk); while (!in_ch.ready);
        n_items++;
        predict_utf8(c, first, budget);
    endtask

    task automatic send_string(input logic [7:0] txt [$], input logic [15:0] budget);
        foreach (txt[i]) begin
            send_word(txt[i], i == 0, (i == 0) ? budget : 16'($urandom));
        end
    endtask

    task automatic release_bus();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        release_bus();
        while (utf8_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_tiny_budgets();
        logic [7:0] txt [$];
        // zero and one byte budgets end on the first word itself
        txt = '{hut_pkg::CHR_UP_A};
        send_string(txt, 16'd0);
        txt = '{hut_pkg::CHR_QUOTE};
        send_string(txt, 16'd1);
        // after the end, words without first_char are dropped
        send_word(hut_pkg::CHR_ZERO, 1'b0, 16'hFFFF);
        txt = '{};
        add_unit(txt, 16'h007F, 0);
        send_string(txt, 16'd2);
    endtask

    task automatic test_unit_classes();
        logic [7:0] txt [$];
        txt = '{hut_pkg::CHR_QUOTE};
        add_unit(txt, 16'hF900, 0);
        add_unit(txt, 16'hF8FF, 0);
        // nul opening the unit after a lead unit is just a digit
        txt.push_back(hut_pkg::CHR_NUL);
        txt.push_back(hex_char(4'hC));
        txt.push_back(hex_char(4'h0));
        txt.push_back(hex_char(4'h0));
        txt.push_back(hut_pkg::CHR_NUL);
        send_string(txt, 16'hFFFF);
    endtask

    task automatic test_no_fit();
        logic [7:0] txt [$];
        txt = '{};
        add_unit(txt, 16'h0800, 0);
        send_string(txt, 16'd3);
    endtask

    task automatic test_random_strings();
        logic [7:0]  txt [$];
        logic [15:0] budget;
        logic [15:0] u;
        int unsigned target;
        int unsigned n_strings;
        int unsigned n_units;
        int unsigned noise_pct;
        int unsigned r;
        target    = n_items + RandItems;
        n_strings = 0;
        while (n_items < target) begin
            txt = '{};
            r = $urandom_range(0, 99);
            if (r < 50) begin
                budget = 16'($urandom_range(0, 12));
            end else if (r < 85) begin
                budget = 16'($urandom_range(13, 60));
            end else begin
                budget = 16'($urandom);
            end
            noise_pct = ($urandom_range(0, 3) == 0) ? 15 : 0;
            if ($urandom_range(0, 99) < 40) txt.push_back(hut_pkg::CHR_QUOTE);
            n_units = $urandom_range(0, 6);
            repeat (n_units) begin
                u = pick_unit();
                add_unit(txt, u, noise_pct);
                if (u > hut_pkg::LIM_3B && u <= hut_pkg::LIM_LEAD) begin
                    add_unit(txt, 16'($urandom), noise_pct);
                end
            end
            r = $urandom_range(0, 99);
            if (r < 45) begin
                txt.push_back(hut_pkg::CHR_NUL);
            end else if (r < 70) begin
                txt.push_back(hut_pkg::CHR_QUOTE);
            end else if (r < 80) begin
                // broken unit cut short by the next string
                repeat ($urandom_range(1, 3)) txt.push_back(hex_char(4'($urandom)));
            end
            if ($urandom_range(0, 99) < 10) begin
                repeat ($urandom_range(1, 2)) txt.push_back(8'($urandom_range(0, 255)));
            end
            if (txt.size() == 0) txt.push_back(hut_pkg::CHR_NUL);
            send_string(txt, budget);
            n_strings++;
            if (n_strings == 4) wait_drained();
        end
    endtask

    // sink side: random stalls with quiet stretches
    initial begin
        int unsigned hold;
        int unsigned calm;
        int unsigned r;
        hold = 0;
        calm = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold != 0) begin
                out_ch.ready <= 1'b0;
                hold--;
            end else begin
                out_ch.ready <= 1'b1;
                if (calm != 0) begin
                    calm--;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 3) begin
                        calm = $urandom_range(20, 80);
                    end else if (r < 25) begin
                        hold = $urandom_range(1, 2);
                    end else if (r < 30) begin
                        hold = $urandom_range(8, 30);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_bytes
        t_utf8_word want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (utf8_q.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected word, expected none, got %02h last %0b reason %0d",
                         $time, out_ch.out_byte, out_ch.last_byte, out_ch.end_reason);
            end else begin
                want = utf8_q.pop_front();
                if (out_ch.out_byte !== want.data || out_ch.last_byte !== want.is_last ||
                    out_ch.end_reason !== want.why) begin
                    n_errors++;
                    $display("%0t: expected %02h last %0b reason %0d, got %02h last %0b reason %0d",
                             $time, want.data, want.is_last, want.why,
                             out_ch.out_byte, out_ch.last_byte, out_ch.end_reason);
                end
            end
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CycleLimit) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        n_errors  = 0;
        n_items   = 0;
        src_calm  = 0;
        unit_acc  = '0;
        nib_cnt   = '0;
        lead_pend = 1'b0;
        lead_val  = '0;
        room      = '0;
        at_start  = 1'b1;
        str_done  = 1'b1;
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.char_in    = '0;
        in_ch.first_char = 1'b0;
        in_ch.out_budget = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_tiny_budgets();
        test_unit_classes();
        test_no_fit();
        test_random_strings();

        wait_drained();
        repeat (DrainCycles) @(posedge i_clk);
        if (n_errors == 0 && utf8_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/hut_pkg.sv
rtl/hut_in_if.sv
rtl/hut_out_if.sv
rtl/hex_ucs2_to_utf8_transcoder_top.sv
verif/hex_ucs2_to_utf8_transcoder_top_test.sv
